/* rtl/reserved_block_bitmap_allocator_core_assert.svh */
// Assertion macros shared by the reserved block bitmap allocator RTL.
`ifndef RESERVED_BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define RESERVED_BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rbba_pkg.sv */
// Shared types, codes and constants of the reserved block bitmap allocator.
package rbba_pkg;

    localparam int RESERVED_BITS_DEF = 4096;

    localparam int BN_W       = 32;
    localparam int CNT_W      = 13;
    localparam int SHIFT_W    = 3;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd3;

    localparam logic [CNT_W-1:0]  COUNT_MAX      = 13'h1FFF;
    localparam logic [WORD_W-1:0] FIRST_BIT_MASK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] ALL_FREE       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BN_W-1:0]   block_number;
    } req_t;

    typedef struct packed {
        logic [BN_W-1:0]  result_block;
        logic [CNT_W-1:0] free_left;
    } rsp_t;

    // Outcome of searching one bitmap word.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } find_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_FREE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

/* rtl/rbba_ram.sv */
// Bitmap word memory: one write port, one read port with registered read data.
module rbba_ram #(
    parameter int WORDS = rbba_pkg::RESERVED_BITS_DEF / 32,
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [rbba_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [rbba_pkg::WORD_W-1:0] rd_data
);
    import rbba_pkg::*;

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    // Write and read ports; read data is registered and appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/rbba_find.sv */
// Search of one bitmap word for the first usable free block, most significant bit first.
module rbba_find #(
    parameter int RESERVED_BITS = rbba_pkg::RESERVED_BITS_DEF,
    localparam int MAP_WORDS = (RESERVED_BITS + 31) / 32,
    localparam int ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    localparam int POS_W = ADDR_W + 5
) (
    input  logic [rbba_pkg::WORD_W-1:0] word_data,
    input  logic [ADDR_W-1:0]           word_idx,
    input  logic [POS_W-1:0]            start_pos,
    input  logic [ADDR_W-1:0]           end_word,
    input  logic                        lim_ok,
    input  logic [rbba_pkg::BN_W-1:0]   lim,
    output rbba_pkg::find_t             hit
);
    import rbba_pkg::*;

    localparam int RB_LAST   = RESERVED_BITS - 1;
    localparam int LAST_WORD = RB_LAST / 32;
    localparam int LAST_BIT  = RB_LAST % 32;

    logic [ADDR_W-1:0] start_word;
    logic [BIT_W-1:0]  start_low;
    logic [26:0]       lim_word;
    logic [26:0]       word_ext;
    logic [BIT_W-1:0]  lo;
    logic [BIT_W-1:0]  hi_rb;
    logic [BIT_W-1:0]  hi_lim;
    logic [BIT_W-1:0]  hi;
    logic              open;

    assign start_word = start_pos[POS_W-1:5];
    assign start_low  = start_pos[4:0];
    assign lim_word   = lim[31:5];
    assign word_ext   = 27'(word_idx);

    // Window of bit positions in this word that the scan may take.
    always_comb
    begin
        lo     = (word_idx == start_word) ? start_low : '0;
        hi_rb  = (word_idx == ADDR_W'(LAST_WORD)) ? BIT_W'(LAST_BIT) : 5'd31;
        open   = lim_ok && (word_idx <= end_word);
        hi_lim = 5'd31;
        priority if (lim_word > word_ext)
        begin
            hi_lim = 5'd31;
        end
        else if (lim_word == word_ext)
        begin
            hi_lim = lim[4:0];
        end
        else
        begin
            open = 1'b0;
        end
        hi = (hi_lim < hi_rb) ? hi_lim : hi_rb;
    end

    // Priority encoder: the lowest position inside the window wins.
    always_comb
    begin
        hit = '0;
        for (int j = 31; j >= 0; j--)
        begin
            if (open && word_data[31 - j] && (BIT_W'(j) >= lo) && (BIT_W'(j) <= hi))
            begin
                hit.found   = 1'b1;
                hit.bit_idx = BIT_W'(j);
            end
        end
    end

endmodule

/* rtl/reserved_block_bitmap_allocator_core.sv */
// Top level of the next-fit reserved block bitmap allocator.
//
// Requests arrive on req (func, block_number) with a valid/ready handshake; each
// request yields exactly one response on rsp (result_block, free_left).
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no request is in flight, as the block does not enforce
// it. The free bitmap lives in a single-port-write, registered-read memory of
// (RESERVED_BITS+31)/32 words, which the controller reads, modifies and
// writes back a word at a time. An allocate reads the roving word and scans
// one word per cycle up to word num_reserved/32, wrapping once back to
// position zero when the search did not start there; a free reads the block's
// word and writes it back; an init sweeps every word to all free; an allocate
// on an empty pool or an ignored request goes straight to the response.
// After reset the controller sweeps the memory to all free with req_ready
// low; configuration writes are taken meanwhile.
// The response sits in an output register: a new request is accepted while it
// waits, and a stalled receiver only holds the next response back.
`include "reserved_block_bitmap_allocator_core_assert.svh"

module reserved_block_bitmap_allocator_core #(
    parameter int RESERVED_BITS = rbba_pkg::RESERVED_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  rbba_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output rbba_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [rbba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rbba_pkg::*;

    localparam int MAP_WORDS = (RESERVED_BITS + 31) / 32;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int POS_W     = ADDR_W + 5;
    localparam int RB_LAST   = RESERVED_BITS - 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

    // Configuration registers.
    logic [BN_W-1:0]    first_reg;
    logic [BN_W-1:0]    last_reg;
    logic [CNT_W-1:0]   num_reg;
    logic [SHIFT_W-1:0] shift_reg;

    // Controller state.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   rov_reg, rov_next;
    logic [ADDR_W-1:0]  word_reg, word_next;
    logic [ADDR_W-1:0]  end_word_reg, end_word_next;
    logic [POS_W-1:0]   start_pos_reg, start_pos_next;
    logic               pass_reg, pass_next;
    logic               lim_ok_reg, lim_ok_next;
    logic [BN_W-1:0]    lim_reg, lim_next;
    logic [BN_W-1:0]    result_reg, result_next;
    logic [POS_W-1:0]   free_pos_reg, free_pos_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    // Memory port signals.
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;

    // Request decode helpers.
    logic               accept;
    logic               slot_free;
    logic [BN_W-1:0]    free_diff;
    logic [BN_W-1:0]    free_shifted;
    logic               free_ok;
    logic [7:0]         num_word;
    logic [POS_W-1:0]   hit_pos;
    logic [BN_W-1:0]    hit_offset;
    find_t              hit;

    assign accept       = req_valid && req_ready;
    assign slot_free    = !rsp_valid_reg || rsp_ready;
    assign free_diff    = req.block_number - first_reg;
    assign free_shifted = free_diff >> shift_reg;
    assign free_ok      = (req.block_number != '0) && (req.block_number >= first_reg)
                          && (req.block_number <= last_reg)
                          && (free_shifted < BN_W'(RESERVED_BITS));
    assign num_word     = num_reg[12:5];
    assign hit_pos      = {word_reg, hit.bit_idx};
    assign hit_offset   = BN_W'(hit_pos) << shift_reg;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    rbba_ram #(
        .WORDS (MAP_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rbba_find #(
        .RESERVED_BITS (RESERVED_BITS)
    ) u_find (
        .word_data (rd_data),
        .word_idx  (word_reg),
        .start_pos (start_pos_reg),
        .end_word  (end_word_reg),
        .lim_ok    (lim_ok_reg),
        .lim       (lim_reg),
        .hit       (hit)
    );

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            last_reg  <= '0;
            num_reg   <= '0;
            shift_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST: first_reg <= cfg_data;
                CFG_LAST:  last_reg  <= cfg_data;
                CFG_NUM:   num_reg   <= cfg_data[CNT_W-1:0];
                CFG_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (word_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.func)
                        FUNC_ALLOC: state_next = (count_reg != '0) ? ST_SCAN : ST_DONE;
                        FUNC_FREE:  state_next = free_ok ? ST_FREE : ST_DONE;
                        FUNC_INIT:  state_next = ST_INIT;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_INIT:
            begin
                if (word_reg == LAST_ADDR)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                priority if (hit.found)
                begin
                    state_next = ST_DONE;
                end
                else if (word_reg < end_word_reg)
                begin
                    state_next = ST_SCAN;
                end
                else if (!pass_reg && (start_pos_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and response loading.
    always_comb
    begin
        count_next     = count_reg;
        rov_next       = rov_reg;
        word_next      = word_reg;
        end_word_next  = end_word_reg;
        start_pos_next = start_pos_reg;
        pass_next      = pass_reg;
        lim_ok_next    = lim_ok_reg;
        lim_next       = lim_reg;
        result_next    = result_reg;
        free_pos_next  = free_pos_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = word_reg;
        wr_data        = ALL_FREE;
        rd_en          = 1'b0;
        rd_addr        = word_reg;

        unique case (state_reg)
            ST_CLEAR, ST_INIT:
            begin
                // Sweep the bitmap to all free, one word per cycle.
                wr_en     = 1'b1;
                wr_addr   = word_reg;
                wr_data   = ALL_FREE;
                word_next = word_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    unique case (req.func)
                        FUNC_ALLOC:
                        begin
                            // Start the scan at the roving word.
                            start_pos_next = rov_reg;
                            word_next      = rov_reg[POS_W-1:5];
                            pass_next      = 1'b0;
                            lim_ok_next    = (last_reg >= first_reg);
                            lim_next       = (last_reg - first_reg) >> shift_reg;
                            end_word_next  = (32'(num_word) > 32'(MAP_WORDS - 1))
                                             ? LAST_ADDR : ADDR_W'(num_word);
                            rd_en          = (count_reg != '0);
                            rd_addr        = rov_reg[POS_W-1:5];
                        end
                        FUNC_FREE:
                        begin
                            free_pos_next = POS_W'(free_shifted);
                            rd_en         = free_ok;
                            rd_addr       = free_shifted[POS_W-1:5];
                        end
                        FUNC_INIT:
                        begin
                            word_next  = '0;
                            count_next = num_reg;
                            rov_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FREE:
            begin
                // Set the released block's bit; the count saturates.
                wr_en   = 1'b1;
                wr_addr = free_pos_reg[POS_W-1:5];
                wr_data = rd_data | (FIRST_BIT_MASK >> free_pos_reg[4:0]);
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                priority if (hit.found)
                begin
                    // Take the block and write the word back.
                    wr_en       = 1'b1;
                    wr_addr     = word_reg;
                    wr_data     = rd_data & ~(FIRST_BIT_MASK >> hit.bit_idx);
                    count_next  = count_reg - CNT_W'(1);
                    rov_next    = hit_pos;
                    result_next = first_reg + hit_offset;
                end
                else if (word_reg < end_word_reg)
                begin
                    word_next = word_reg + ADDR_W'(1);
                    rd_en     = 1'b1;
                    rd_addr   = word_reg + ADDR_W'(1);
                end
                else if (!pass_reg && (start_pos_reg != '0))
                begin
                    // Wrap once and search again from position zero.
                    pass_next      = 1'b1;
                    start_pos_next = '0;
                    rov_next       = '0;
                    word_next      = '0;
                    rd_en          = 1'b1;
                    rd_addr        = '0;
                end
                else
                begin
                    rov_next    = '0;
                    result_next = '0;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.result_block = result_reg;
                    rsp_next.free_left    = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            count_reg     <= '0;
            rov_reg       <= '0;
            word_reg      <= '0;
            pass_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rov_reg       <= rov_next;
            word_reg      <= word_next;
            pass_reg      <= pass_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        end_word_reg  <= end_word_next;
        start_pos_reg <= start_pos_next;
        lim_ok_reg    <= lim_ok_next;
        lim_reg       <= lim_next;
        result_reg    <= result_next;
        free_pos_reg  <= free_pos_next;
        rsp_reg       <= rsp_next;
    end

    // Checks on the controller.
    `RBBA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE,
        "accepted transaction did not start work")
    `RBBA_ASSERT_NOW(a_no_rw_same_word, wr_en && rd_en, wr_addr != rd_addr,
        "bitmap word read and written in the same cycle")
    `RBBA_ASSERT_NEXT(a_alloc_counts_down, (state_reg == ST_SCAN) && hit.found,
        count_reg == $past(count_reg) - CNT_W'(1), "allocation did not consume a free block")
    `RBBA_ASSERT_NOW(a_roving_in_map, 1'b1, rov_reg <= POS_W'(RB_LAST),
        "roving position beyond the bitmap")

endmodule

/* bench/reserved_block_bitmap_allocator_core_tb.sv */
// Self-checking testbench for the next-fit reserved block bitmap allocator.
module reserved_block_bitmap_allocator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rbba_pkg::*;

    localparam int MAP_BITS  = RESERVED_BITS_DEF;
    localparam int MAP_WORDS = MAP_BITS / WORD_W;

    // Function code that the block must answer without touching its state.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Longest quiet stretch of a correct run: the long receiver hold, a
    // wrapped scan of every map word, the sweep after reset and the longest
    // sender gap. The limit lies well above their sum.
    localparam int QUIET_LIMIT = 4000;

    localparam int PHASE_ITEMS = 125;
    localparam int RANDOM_PHASES = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 300;

    // Keeps its own copy of the bitmap, the counters and the registers, and
    // holds the answers owed for accepted requests in order.
    class alloc_ledger;
        logic [BN_W-1:0]   first_blk;
        logic [BN_W-1:0]   last_blk;
        logic [CNT_W-1:0]  pool_size;
        logic [SHIFT_W-1:0] shift;
        logic [WORD_W-1:0] map_words [MAP_WORDS];
        logic [CNT_W-1:0]  count;
        logic [11:0]       rover;
        rsp_t              owed [$];
        int                errors;

        function new();
            first_blk = '0;
            last_blk  = '0;
            pool_size = '0;
            shift     = '0;
            foreach (map_words[i])
                map_words[i] = ALL_FREE;
            count  = '0;
            rover  = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FIRST: first_blk = data;
                CFG_LAST:  last_blk  = data;
                CFG_NUM:   pool_size = data[CNT_W-1:0];
                CFG_SHIFT: shift     = data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        // Scans for the first free bit from start whose block number, formed
        // without wrapping, does not exceed last_blk.
        function bit search_from(int start, output logic [BN_W-1:0] blk);
            int          last_word;
            int          p;
            logic [63:0] cand;
            blk = '0;
            last_word = int'(pool_size) >> 5;
            if (last_word > MAP_WORDS - 1)
                last_word = MAP_WORDS - 1;
            for (p = start; p < MAP_BITS && (p >> 5) <= last_word; p++)
            begin
                if (map_words[p >> 5][31 - (p & 31)])
                begin
                    cand = 64'(first_blk) + (64'(p) << shift);
                    if (cand <= 64'(last_blk))
                    begin
                        map_words[p >> 5][31 - (p & 31)] = 1'b0;
                        count = count - CNT_W'(1);
                        rover = 12'(p);
                        blk = cand[BN_W-1:0];
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        // Next-fit allocation with a single retry from position zero.
        function logic [BN_W-1:0] allocate();
            logic [BN_W-1:0] blk;
            if (count == '0)
                return '0;
            if (search_from(int'(rover), blk))
                return blk;
            if (rover != '0)
            begin
                rover = '0;
                if (search_from(0, blk))
                    return blk;
            end
            return '0;
        endfunction

        // Out-of-range numbers are ignored; a double free still counts.
        function void give_back(logic [BN_W-1:0] bn);
            logic [BN_W-1:0] p;
            if (bn == '0 || bn < first_blk || bn > last_blk)
                return;
            p = (bn - first_blk) >> shift;
            if (p >= MAP_BITS)
                return;
            map_words[p[11:5]][5'd31 - p[4:0]] = 1'b1;
            if (count != COUNT_MAX)
                count = count + CNT_W'(1);
        endfunction

        // Called for every accepted request transaction.
        function void note_request(req_t r);
            rsp_t a;
            a.result_block = '0;
            case (r.func)
                FUNC_ALLOC: a.result_block = allocate();
                FUNC_FREE:  give_back(r.block_number);
                FUNC_INIT:
                begin
                    foreach (map_words[i])
                        map_words[i] = ALL_FREE;
                    count = pool_size;
                    rover = '0;
                end
                default: ;
            endcase
            a.free_left = count;
            owed.push_back(a);
        endfunction

        // Called for every accepted response transaction.
        function void check_answer(rsp_t got);
            rsp_t want;
            if (owed.size() == 0)
            begin
                $error("response with none outstanding: result_block %0h free_left %0d",
                       got.result_block, got.free_left);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.result_block !== want.result_block)
            begin
                $error("result_block: expected %0h, got %0h", want.result_block,
                       got.result_block);
                errors++;
            end
            if (got.free_left !== want.free_left)
            begin
                $error("free_left: expected %0d, got %0d", want.free_left, got.free_left);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alloc_ledger ledger;

    // Register values currently in force, used to aim the stimulus.
    logic [BN_W-1:0]    reg_first;
    logic [BN_W-1:0]    reg_last;
    logic [CNT_W-1:0]   reg_num;
    logic [SHIFT_W-1:0] reg_shift;

    int burst_left;
    bit long_hold;

    reserved_block_bitmap_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic req_t make_req(logic [FUNC_W-1:0] func, logic [BN_W-1:0] bn);
        req_t x;
        x.func = func;
        x.block_number = bn;
        return x;
    endfunction

    // Presents one request at a falling edge and holds it until accepted.
    task automatic put_req(input req_t r);
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        ledger.note_request(r);
        @(negedge clk);
    endtask

    // The sender works in bursts; between bursts valid drops for a gap.
    task automatic offer(input req_t r);
        int roll;
        int gap;
        if (burst_left == 0)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 3)
                gap = 0;
            else if (roll < 9)
                gap = $urandom_range(1, 6);
            else
                gap = $urandom_range(15, 40);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        put_req(r);
    endtask

    // Stops offering and waits until every owed answer has come back.
    task automatic drain();
        req_valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (ledger.pending() != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        ledger.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_config(input logic [BN_W-1:0] first, input logic [BN_W-1:0] last,
                                input logic [CNT_W-1:0] num, input logic [SHIFT_W-1:0] shift);
        reg_first = first;
        reg_last  = last;
        reg_num   = num;
        reg_shift = shift;
        put_reg(CFG_FIRST, first);
        put_reg(CFG_LAST, last);
        put_reg(CFG_NUM, CFG_DATA_W'(num));
        put_reg(CFG_SHIFT, CFG_DATA_W'(shift));
        cfg_we <= 1'b0;
    endtask

    // Register settings for each random phase, extremes included.
    task automatic phase_config(input int ph);
        logic [CNT_W-1:0]   n;
        logic [SHIFT_W-1:0] s;
        logic [BN_W-1:0]    f;
        s = SHIFT_W'($urandom_range(0, 7));
        case (ph)
            0:
            begin
                n = CNT_W'($urandom_range(1, 64));
                write_config('0, BN_W'(n) + 32'd10, n, '0);
            end
            1: write_config(32'd1, '1, CNT_W'($urandom_range(1, 40)), 3'd7);
            2: write_config(BN_W'($urandom_range(1, 1000)), '1, 13'd4096, s);
            3: write_config('0, '0, CNT_W'($urandom_range(1, 64)), s);
            4:
            begin
                f = 32'hFFFF_FFFF - BN_W'($urandom_range(0, 2000));
                write_config(f, '1, CNT_W'($urandom_range(1, 100)), s);
            end
            5: write_config($urandom(), $urandom(), CNT_W'($urandom_range(0, 300)), s);
            6:
            begin
                n = CNT_W'($urandom_range(16, 200));
                f = BN_W'($urandom_range(0, 5000));
                write_config(f, f + (BN_W'(n >> 1) << s), n, s);
            end
            default: write_config('1, '1, '0, s);
        endcase
    endtask

    // Mostly allocations and well-aimed frees; the rest is noise that the
    // block either ignores or that has an unusual shape.
    function automatic req_t random_item(output bit useful);
        int unsigned roll;
        int unsigned pos;
        logic [63:0] wide;
        req_t        r;
        useful = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            r = make_req(FUNC_ALLOC, $urandom());
        else if (roll < 80)
        begin
            pos = $urandom_range(0, 32'(reg_num) + 32'd8);
            wide = 64'(reg_first) + (64'(pos) << reg_shift)
                 + 64'($urandom() & ((32'd1 << reg_shift) - 32'd1));
            r = make_req(FUNC_FREE, wide[BN_W-1:0]);
        end
        else if (roll < 84)
            r = make_req(FUNC_INIT, $urandom());
        else
        begin
            useful = 1'b0;
            case ($urandom_range(0, 4))
                0: r = make_req(FUNC_W'($urandom_range(0, 3)), $urandom());
                1: r = make_req(FUNC_FREE, '0);
                2: r = make_req(FUNC_FREE, reg_first - BN_W'(1));
                3: r = make_req(FUNC_FREE, reg_last + BN_W'(1));
                default: r = make_req(FUNC_UNUSED, $urandom());
            endcase
        end
        return r;
    endfunction

    // Receiver: changes its stall pattern every so often, and on request
    // holds off for a long stretch so that the block backs up.
    initial
    begin
        int mode;
        int window;
        int hold;
        rsp_ready = 1'b0;
        mode = 0;
        window = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (window == 0)
                begin
                    mode = $urandom_range(0, 3);
                    window = $urandom_range(20, 120);
                end
                window--;
                case (mode)
                    2: rsp_ready <= ($urandom_range(0, 3) != 0);
                    3: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= 1'b1;
                endcase
            end
        end
    end

    // Response checking at each rising edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                ledger.check_answer(rsp);
        end
    end

    // Watchdog: ends the run if no transaction moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("reserved_block_bitmap_allocator_core_tb: done, errors");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        req_t item;
        bit   useful;
        int   done;
        bit   stalled_once;
        ledger = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_FIRST;
        cfg_data = '0;
        reg_first = '0;
        reg_last = '0;
        reg_num = '0;
        reg_shift = '0;
        burst_left = 0;
        long_hold = 1'b0;
        stalled_once = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers at reset: the pool is empty, and block zero is out of range.
        offer(make_req(FUNC_ALLOC, '0));
        offer(make_req(FUNC_FREE, '0));
        offer(make_req(FUNC_UNUSED, '1));
        drain();

        // Block zero handed out, a double free, and a free above the range.
        write_config('0, 32'd100, 13'd40, 3'd0);
        offer(make_req(FUNC_INIT, '0));
        offer(make_req(FUNC_ALLOC, '1));
        offer(make_req(FUNC_ALLOC, '0));
        offer(make_req(FUNC_FREE, 32'd1));
        offer(make_req(FUNC_FREE, 32'd1));
        offer(make_req(FUNC_FREE, 32'd101));
        drain();

        // Three usable positions: drain the pool, free below and above the
        // range, then let the count run ahead of the map so the search fails
        // even after the retry from zero.
        write_config(32'd10, 32'd18, 13'd3, 3'd2);
        offer(make_req(FUNC_INIT, '0));
        repeat (4) offer(make_req(FUNC_ALLOC, '0));
        offer(make_req(FUNC_FREE, 32'd9));
        offer(make_req(FUNC_FREE, 32'd19));
        offer(make_req(FUNC_FREE, 32'd14));
        offer(make_req(FUNC_FREE, 32'd14));
        offer(make_req(FUNC_ALLOC, '0));
        offer(make_req(FUNC_ALLOC, '0));
        drain();

        // Block numbers that would overflow 32 bits, and a full-length scan.
        write_config(32'hFFFF_FF00, '1, 13'd4096, 3'd7);
        offer(make_req(FUNC_INIT, '0));
        repeat (3) offer(make_req(FUNC_ALLOC, '0));
        offer(make_req(FUNC_FREE, '1));
        drain();

        // A position past the map, then the free count at its ceiling.
        write_config(32'd1, '1, 13'd8190, 3'd0);
        offer(make_req(FUNC_INIT, '0));
        offer(make_req(FUNC_FREE, 32'd4097));
        offer(make_req(FUNC_FREE, 32'd4096));
        offer(make_req(FUNC_FREE, 32'd4096));
        drain();

        // Random phases, each starting from a fresh bitmap.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            phase_config(ph);
            offer(make_req(FUNC_INIT, $urandom()));
            done = 1;
            while (done < PHASE_ITEMS)
            begin
                item = random_item(useful);
                offer(item);
                if (useful)
                    done++;
                if (ph == 1 && done == 20 && !stalled_once)
                begin
                    stalled_once = 1'b1;
                    long_hold = 1'b1;
                end
                if (ph == 4 && done == PHASE_ITEMS / 2 && useful)
                    drain();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.errors == 0)
            $display("reserved_block_bitmap_allocator_core_tb: done, clean");
        else
            $display("reserved_block_bitmap_allocator_core_tb: done, errors");
        $finish;
    end

endmodule
